// ===== hw/rtl/skoi_pkg.sv =====
`default_nettype none

package skoi_pkg;

    // Table geometry.
    localparam int DEPTH     = 256;
    localparam int KEY_CHARS = 5;
    localparam int KEY_W     = 8 * KEY_CHARS;
    localparam int OFF_W     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int POS_W     = 8;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] rec_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic [OFF_W-1:0] found_offset;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] offset;
    } entry_t;

    // Status of one binary search step.
    typedef struct packed {
        logic             searching;
        logic [CNT_W-1:0] mid;
        logic             less;
        logic             equal;
    } probe_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skoi_probe.sv =====
`default_nettype none

// Binary search step: midpoint of the open range and the key compare.
module skoi_probe (
    input  wire logic [skoi_pkg::CNT_W-1:0] lo,
    input  wire logic [skoi_pkg::CNT_W-1:0] hi,
    input  wire logic [skoi_pkg::KEY_W-1:0] probe_key,
    input  wire logic [skoi_pkg::KEY_W-1:0] target_key,
    output skoi_pkg::probe_t                result
);
    import skoi_pkg::*;

    logic [CNT_W-1:0] span;

    always_comb
    begin
        span             = hi - lo;
        result.searching = (lo < hi);
        result.mid       = lo + (span >> 1);
        // Packed keys compare as unsigned integers, which matches string order.
        result.less      = (probe_key < target_key);
        result.equal     = (probe_key == target_key);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_offset_index_core.sv =====
`default_nettype none

// Sorted key/offset index of up to 256 entries held in one single-port-write,
// one-port-read memory with registered read data. A request is taken only
// while the sequencer is idle. Every operation runs a binary search in which
// each probe is a memory read followed by a compare, with at most
// ceil(log2(count+1)) probes, and then a check of the final position before
// the result is handed to the output register. An insert additionally moves
// every entry at and above the insert point up by one and a delete moves
// every entry above the removed one down by one, each move a read and then a
// write through the same memory port. The response waits in an output
// register, and the next request can be taken while it is still pending.
module sorted_key_offset_index_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire skoi_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output skoi_pkg::rsp_t      rsp
);
    import skoi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_CHECK,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_EMIT
    } state_t;

    state_t           state_reg,      state_next;
    logic [1:0]       op_reg,         op_next;
    logic [KEY_W-1:0] key_reg,        key_next;
    logic [OFF_W-1:0] off_reg,        off_next;
    logic [CNT_W-1:0] lo_reg,         lo_next;
    logic [CNT_W-1:0] hi_reg,         hi_next;
    logic [CNT_W-1:0] ptr_reg,        ptr_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [POS_W-1:0] res_pos_reg,    res_pos_next;
    logic [OFF_W-1:0] res_found_reg,  res_found_next;
    logic             rsp_valid_reg,  rsp_valid_next;
    rsp_t             rsp_reg,        rsp_next;

    // Memory ports.
    entry_t           mem [DEPTH];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    probe_t           probe;
    logic             present;
    logic [CNT_W-1:0] ptr_dec;
    logic [CNT_W-1:0] ptr_inc;

    skoi_probe u_probe (
        .lo         (lo_reg),
        .hi         (hi_reg),
        .probe_key  (rd_data_reg.key),
        .target_key (key_reg),
        .result     (probe)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign present = (lo_reg < count_reg) && probe.equal;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        off_next        = off_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_found_next  = res_found_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        rd_addr         = lo_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.op;
                    key_next   = req.key;
                    off_next   = req.rec_offset;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_PROBE;
                end
            end

            // Read the midpoint, or the final lower bound once the range is empty.
            S_PROBE:
            begin
                if (probe.searching)
                begin
                    rd_addr    = probe.mid[IDX_W-1:0];
                    ptr_next   = probe.mid;
                    state_next = S_CMP;
                end
                else
                begin
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = S_CHECK;
                end
            end

            // Narrow the range on the key read at the midpoint.
            S_CMP:
            begin
                if (probe.less)
                begin
                    lo_next = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = ptr_reg;
                end
                state_next = S_PROBE;
            end

            // Decide the outcome at the lower bound.
            S_CHECK:
            begin
                res_status_next = ST_NOT_FOUND;
                res_pos_next    = '0;
                res_found_next  = '0;
                state_next      = S_EMIT;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (present)
                        begin
                            res_status_next = ST_DUPLICATE;
                            res_pos_next    = lo_reg[POS_W-1:0];
                        end
                        else if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            res_pos_next    = lo_reg[POS_W-1:0];
                            ptr_next        = count_reg;
                            state_next      = S_INS_RD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (present)
                        begin
                            res_status_next = ST_OK;
                            res_pos_next    = lo_reg[POS_W-1:0];
                            res_found_next  = rd_data_reg.offset;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (present)
                        begin
                            res_status_next = ST_OK;
                            res_pos_next    = lo_reg[POS_W-1:0];
                            res_found_next  = rd_data_reg.offset;
                            ptr_next        = lo_reg;
                            state_next      = S_DEL_RD;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
            end

            // Open a gap: move entries up from the top down to the insert point.
            S_INS_RD:
            begin
                if (ptr_reg == lo_reg)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = lo_reg[IDX_W-1:0];
                    wr_data.key    = key_reg;
                    wr_data.offset = off_reg;
                    count_next     = count_reg + CNT_W'(1);
                    state_next     = S_EMIT;
                end
                else
                begin
                    rd_addr    = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                ptr_next   = ptr_dec;
                state_next = S_INS_RD;
            end

            // Close the gap: move entries above the removed one down by one.
            S_DEL_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    rd_addr    = ptr_inc[IDX_W-1:0];
                    state_next = S_DEL_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_DEL_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg[IDX_W-1:0];
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end

            // Hand the result to the output register once it is free.
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = res_status_reg;
                    rsp_next.position     = res_pos_reg;
                    rsp_next.found_offset = res_found_reg;
                    rsp_next.entry_count  = count_reg;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            key_reg        <= '0;
            off_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            res_status_reg <= '0;
            res_pos_reg    <= '0;
            res_found_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            off_reg        <= off_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            ptr_reg        <= ptr_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            res_found_reg  <= res_found_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    // Entry memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // The entry count never exceeds the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    // The search range stays ordered and inside the valid entries.
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search range out of order");

    // The count moves by at most one per operation.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // The count changes only when an operation finishes.
    a_count_when: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (state_reg == S_EMIT))
        else $error("entry count changed outside completion");
`endif

endmodule

`default_nettype wire
